>>> rtl/core/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// No dependencies; compiled out when NO_ASSERTIONS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, cond)
`endif
`endif

>>> rtl/core/spr_pkg.sv
// Types and constants for the sensor packet ASCII record formatter.
// No dependencies; used by every module in rtl/core.
package spr_pkg;

  localparam int RecLen     = 27;
  localparam int ReadOffset = 1000;
  localparam int ReadMax    = 9999;
  localparam int ByteMax    = 99;
  localparam int NumLanes   = 5;   // three readings, two bytes
  localparam int BinWidth   = 14;  // holds up to 9999
  localparam int BcdWidth   = 16;  // four decimal digits
  localparam int QueueDepth = 2;

  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTagA    = 8'h41;
  localparam logic [7:0] ChTagF    = 8'h46;
  localparam logic [7:0] ChTagK    = 8'h4B;

  typedef struct packed {
    logic [2:0] pipe_number;
    logic [7:0] payload_byte_0;
    logic [7:0] payload_byte_1;
    logic [7:0] payload_byte_2;
    logic [7:0] payload_byte_3;
    logic [7:0] payload_byte_4;
    logic [7:0] payload_byte_5;
    logic [7:0] payload_byte_6;
    logic [7:0] payload_byte_7;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_record;
  } out_t;

  // one converted record: BCD digits per lane plus first tag letter
  typedef struct packed {
    logic [NumLanes-1:0][BcdWidth-1:0] bcd;
    logic [7:0]                        tag_base;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/core/spr_front.sv
// Front end: takes a packet, forms saturated values, converts them to BCD.
// Depends on spr_pkg.
module spr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spr_pkg::in_t      in_data,
  output logic              push,
  output spr_pkg::rec_t     push_data,
  input  spr_pkg::q_status_t q_status
);

  localparam int NL   = spr_pkg::NumLanes;
  localparam int BW   = spr_pkg::BinWidth;
  localparam int DW   = spr_pkg::BcdWidth;
  localparam int CntW = $clog2(BW);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_PUSH = 2'd2;

  logic [1:0]                state;
  logic [CntW-1:0]           cnt;
  logic [NL-1:0][BW-1:0]     bin;
  logic [NL-1:0][DW-1:0]     bcd;
  logic [NL-1:0][DW-1:0]     bcd_adj;
  logic [7:0]                tag_base;
  logic [NL-1:0][BW-1:0]     load_val;
  logic                      accept;

  function automatic logic [BW-1:0] sat_reading(input logic [7:0] lo, input logic [7:0] hi);
    logic [16:0] sum;
    sum = {1'b0, hi, lo} + 17'(spr_pkg::ReadOffset);
    if (sum > 17'(spr_pkg::ReadMax)) begin
      return BW'(spr_pkg::ReadMax);
    end
    return sum[BW-1:0];
  endfunction

  function automatic logic [BW-1:0] sat_byte(input logic [7:0] b);
    if (b > 8'(spr_pkg::ByteMax)) begin
      return BW'(spr_pkg::ByteMax);
    end
    return BW'(b);
  endfunction

  assign accept   = in_valid && (state == S_IDLE);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    load_val[0] = sat_reading(in_data.payload_byte_4, in_data.payload_byte_5);
    load_val[1] = sat_reading(in_data.payload_byte_2, in_data.payload_byte_3);
    load_val[2] = sat_reading(in_data.payload_byte_0, in_data.payload_byte_1);
    load_val[3] = sat_byte(in_data.payload_byte_6);
    load_val[4] = sat_byte(in_data.payload_byte_7);
  end

  // double dabble: add 3 to any digit of 5 or more before each shift
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int d = 0; d < DW / 4; d++) begin
        bcd_adj[l][4*d +: 4] = (bcd[l][4*d +: 4] >= 4'd5) ?
                               bcd[l][4*d +: 4] + 4'd3 : bcd[l][4*d +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
            cnt   <= '0;
          end
        end
        S_CONV: begin
          if (cnt == CntW'(BW - 1)) begin
            state <= S_PUSH;
          end
          cnt <= cnt + 1'b1;
        end
        S_PUSH: begin
          if (!q_status.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin <= load_val;
      bcd <= '0;
      unique case (in_data.pipe_number)
        3'd0:    tag_base <= spr_pkg::ChTagA;
        3'd1:    tag_base <= spr_pkg::ChTagF;
        default: tag_base <= spr_pkg::ChTagK;
      endcase
    end else if (state == S_CONV) begin
      for (int l = 0; l < NL; l++) begin
        bcd[l] <= {bcd_adj[l][DW-2:0], bin[l][BW-1]};
        bin[l] <= {bin[l][BW-2:0], 1'b0};
      end
    end
  end

  assign push               = (state == S_PUSH) && !q_status.full;
  assign push_data.bcd      = bcd;
  assign push_data.tag_base = tag_base;

endmodule

>>> rtl/core/spr_queue.sv
// Short FIFO of converted records between front and back.
// Depends on spr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spr_queue #(
  parameter int Depth = spr_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  spr_pkg::rec_t      push_data,
  input  logic               pop,
  output spr_pkg::rec_t      head,
  output spr_pkg::q_status_t status
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  spr_pkg::rec_t  slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst, push && status.full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && status.empty)
  `ASSERT_CLK(a_count_range, clk, rst, count <= CntW'(Depth))

endmodule

>>> rtl/core/spr_back.sv
// Back end: walks the head record, emitting one ASCII byte per cycle while a record is queued and not stalled.
// Depends on spr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module spr_back (
  input  logic               clk,
  input  logic               rst,
  input  spr_pkg::rec_t      head,
  input  spr_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output spr_pkg::out_t      out_data
);

  localparam int PosW = $clog2(spr_pkg::RecLen);

  logic [PosW-1:0] pos;
  logic            load;
  logic            at_end;
  logic [7:0]      ch;

  function automatic logic [7:0] rec_char(input spr_pkg::rec_t r, input logic [PosW-1:0] p);
    logic [2:0] lane;
    logic [2:0] slot;
    logic [1:0] di;
    logic       small_val;
    lane      = '0;
    slot      = '0;
    small_val = 1'b0;
    if (p < PosW'(6)) begin
      lane = 3'd0; slot = 3'(p);
    end else if (p < PosW'(12)) begin
      lane = 3'd1; slot = 3'(p - PosW'(6));
    end else if (p < PosW'(18)) begin
      lane = 3'd2; slot = 3'(p - PosW'(12));
    end else if (p < PosW'(22)) begin
      lane = 3'd3; slot = 3'(p - PosW'(18)); small_val = 1'b1;
    end else begin
      lane = 3'd4; slot = 3'(p - PosW'(22)); small_val = 1'b1;
    end
    if (p == PosW'(spr_pkg::RecLen - 1)) begin
      return spr_pkg::ChNewline;
    end
    // readings: 4 digits, tag, comma; bytes: 2 digits, tag, comma
    if (small_val) begin
      if (slot == 3'd2) return r.tag_base + 8'(lane);
      if (slot == 3'd3) return spr_pkg::ChComma;
      di = (slot == 3'd0) ? 2'd1 : 2'd0;
    end else begin
      if (slot == 3'd4) return r.tag_base + 8'(lane);
      if (slot == 3'd5) return spr_pkg::ChComma;
      di = 2'd3 - slot[1:0];
    end
    return spr_pkg::ChZero + 8'(r.bcd[lane][4*di +: 4]);
  endfunction

  assign ch     = rec_char(head, pos);
  assign at_end = (pos == PosW'(spr_pkg::RecLen - 1));
  assign load   = !q_status.empty && (!out_valid || !out_stall);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        pos       <= at_end ? '0 : pos + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte       <= ch;
      out_data.last_of_record <= at_end;
    end
  end

  `ASSERT_CLK(a_last_is_newline, clk, rst,
              out_valid && out_data.last_of_record |-> out_data.out_byte == spr_pkg::ChNewline)
  `ASSERT_CLK(a_pos_range, clk, rst, pos <= PosW'(spr_pkg::RecLen - 1))
  `ASSERT_CLK(a_pop_wraps, clk, rst, pop |=> pos == '0)

endmodule

>>> rtl/core/sensor_packet_ascii_record_formatter_top.sv
// The back end emits one output byte per cycle while the record queue holds a record
// and out_stall is low; the front end's 14-step BCD conversion overlaps the previous
// record's output. Input stalls after each packet until its record is converted and
// pushed into the queue, which waits while the record queue is full.
// Reset (rst, synchronous) empties the queue and clears front and back control state.
module sensor_packet_ascii_record_formatter_top #(
  parameter int QueueDepth = spr_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  spr_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output spr_pkg::out_t out_data
);

  logic               push;
  logic               pop;
  spr_pkg::rec_t      push_data;
  spr_pkg::rec_t      head;
  spr_pkg::q_status_t q_status;

  spr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_status  (q_status)
  );

  spr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  spr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
